FILE: design/pe_pkg.sv
package pe_pkg;

  // Field and state widths fixed by the interface.
  localparam int LVL_W   = 4;   // level numbers, tries, stored positions, n_size
  localparam int NIB_W   = 4;   // one placed value
  localparam int POS_W   = 5;   // scan position, one bit of headroom for the increment
  localparam int PLACE_W = 48;  // packed placement, twelve nibbles
  localparam int SEQ_W   = 29;  // permutation counter

  localparam logic [LVL_W-1:0] N_SIZE_RESET = 4'd11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_SCAN,
    ST_OUT
  } st_t;

  // One write into the slot register file.
  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] pos;
    logic [NIB_W-1:0] val;
  } slot_wr_t;

endpackage

FILE: design/permutation_enumerator.sv
// Backtracking permutation enumerator. Each input word asks for the next
// permutation of positions 1..n (n from the cfg_n_size register, saturated
// to MAX_ELEMS), or with in_restart set clears the search and returns the
// first one. Exactly one result word comes back per input word: the
// placement as 4-bit values (position p in bits 4*(p-1) up), a running
// sequence number, and an exhausted flag with a zero placement once the
// search tree is finished; exhausted repeats until a restart. The block
// handles one request at a time: in_stall is high from the accept until the
// result word has been taken. A request passes through an accept step, a
// level visit for every level entered, a scan for a free position that
// skips each occupied slot at every level that scans, and an output step.
// The single slot-scan incrementer probes one position per cycle. The
// n_size register should be written only while no request is in flight;
// cfg_ready is always high.
module permutation_enumerator #(
  parameter int MAX_ELEMS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pe_pkg::LVL_W-1:0]   cfg_n_size,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_restart,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pe_pkg::PLACE_W-1:0] out_placement,
  output logic [pe_pkg::SEQ_W-1:0]   out_sequence_number,
  output logic                       out_exhausted
);
  import pe_pkg::*;

  localparam int IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;

  st_t              state_r, state_nxt;
  logic [LVL_W-1:0] n_size_r, n_size_nxt;
  logic [LVL_W-1:0] tries_r [MAX_ELEMS];
  logic [LVL_W-1:0] tries_nxt [MAX_ELEMS];
  logic [LVL_W-1:0] pos_r [MAX_ELEMS];
  logic [LVL_W-1:0] pos_nxt [MAX_ELEMS];
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [SEQ_W-1:0] count_r, count_nxt;
  logic             finished_r, finished_nxt;
  logic [POS_W-1:0] scan_pos_r, scan_pos_nxt;
  logic [LVL_W-1:0] probes_r, probes_nxt;
  logic [PLACE_W-1:0] placement_r, placement_nxt;
  logic [SEQ_W-1:0]   seq_r, seq_nxt;
  logic               exh_r, exh_nxt;

  logic [LVL_W-1:0] nn;
  logic [LVL_W-1:0] lvl_m1;
  logic [IDX_W-1:0] didx;
  logic [LVL_W-1:0] cur_tries;
  logic [LVL_W-1:0] cur_pos;
  logic             active;
  logic             can_try;
  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] scan_inc;

  logic             slot_clr;
  slot_wr_t         slot_wr;
  logic [POS_W-1:0] rd_pos;
  logic [NIB_W-1:0] rd_data;
  logic [PLACE_W-1:0] packed_place;

  assign nn = (n_size_r > LVL_W'(MAX_ELEMS)) ? LVL_W'(MAX_ELEMS) : n_size_r;

  // The level register only indexes the stack while it lies in 1..MAX_ELEMS.
  assign lvl_m1    = level_r - LVL_W'(1);
  assign didx      = lvl_m1[IDX_W-1:0];
  assign cur_tries = tries_r[didx];
  assign cur_pos   = pos_r[didx];
  assign active    = !finished_r && (level_r != '0) && (level_r <= LVL_W'(MAX_ELEMS));
  assign can_try   = ({1'b0, cur_tries} + {1'b0, level_r}) <= {1'b0, nn};

  // The one read port of the slot store follows the stack top while a level
  // is entered, and the scan pointer while searching for a free slot.
  assign rd_pos   = (state_r == ST_SCAN) ? scan_pos_r : {1'b0, cur_pos};
  assign scan_inc = scan_pos_r + POS_W'(1);

  pe_slot_file #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_slots (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (slot_clr),
    .wr        (slot_wr),
    .rd_pos    (rd_pos),
    .rd_data   (rd_data),
    .nn        (nn),
    .ovr_pos   (scan_pos_r),
    .ovr_val   (level_r),
    .placement (packed_place)
  );

  assign cfg_ready           = 1'b1;
  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = (state_r == ST_OUT);
  assign out_placement       = placement_r;
  assign out_sequence_number = seq_r;
  assign out_exhausted       = exh_r;

  always_comb begin
    state_nxt     = state_r;
    n_size_nxt    = n_size_r;
    tries_nxt     = tries_r;
    pos_nxt       = pos_r;
    level_nxt     = level_r;
    count_nxt     = count_r;
    finished_nxt  = finished_r;
    scan_pos_nxt  = scan_pos_r;
    probes_nxt    = probes_r;
    placement_nxt = placement_r;
    seq_nxt       = seq_r;
    exh_nxt       = exh_r;
    slot_clr      = 1'b0;
    slot_wr       = '0;
    start_pos     = {1'b0, cur_pos};

    if (cfg_valid && cfg_ready) begin
      n_size_nxt = cfg_n_size;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_restart) begin
            slot_clr = 1'b1;
            for (int i = 0; i < MAX_ELEMS; i++) begin
              tries_nxt[i] = '0;
              pos_nxt[i]   = LVL_W'(i + 1);
            end
            level_nxt    = LVL_W'(1);
            count_nxt    = '0;
            finished_nxt = 1'b0;
          end
          state_nxt = ST_LEVEL;
        end
      end

      ST_LEVEL: begin
        if (!active) begin
          // Search tree finished: report the total count with no placement.
          finished_nxt  = 1'b1;
          placement_nxt = '0;
          seq_nxt       = count_r;
          exh_nxt       = 1'b1;
          state_nxt     = ST_OUT;
        end else if (can_try) begin
          tries_nxt[didx] = cur_tries + LVL_W'(1);
          // Lift this level's value off its old slot and start past it.
          if (rd_data == level_r) begin
            slot_wr.en  = 1'b1;
            slot_wr.pos = {1'b0, cur_pos};
            slot_wr.val = '0;
            start_pos   = {1'b0, cur_pos} + POS_W'(1);
          end
          if ((start_pos == '0) || (start_pos > {1'b0, nn})) begin
            start_pos = POS_W'(1);
          end
          scan_pos_nxt = start_pos;
          probes_nxt   = '0;
          state_nxt    = ST_SCAN;
        end else begin
          // Tries used up: clear this level and step back one.
          tries_nxt[didx] = '0;
          slot_wr.en      = 1'b1;
          slot_wr.pos     = {1'b0, cur_pos};
          slot_wr.val     = '0;
          pos_nxt[didx]   = cur_pos + LVL_W'(1);
          level_nxt       = lvl_m1;
        end
      end

      ST_SCAN: begin
        if ((rd_data != '0) && (probes_r < nn)) begin
          scan_pos_nxt = (scan_inc > {1'b0, nn}) ? POS_W'(1) : scan_inc;
          probes_nxt   = probes_r + LVL_W'(1);
        end else if (rd_data == '0) begin
          pos_nxt[didx] = scan_pos_r[LVL_W-1:0];
          if (level_r == nn) begin
            // Last level placed: the placement is complete. The slot is
            // left free again, so no write is needed.
            placement_nxt   = packed_place;
            count_nxt       = count_r + SEQ_W'(1);
            seq_nxt         = count_r + SEQ_W'(1);
            exh_nxt         = 1'b0;
            tries_nxt[didx] = '0;
            level_nxt       = lvl_m1;
            if (lvl_m1 == '0) begin
              finished_nxt = 1'b1;
            end
            state_nxt = ST_OUT;
          end else begin
            slot_wr.en  = 1'b1;
            slot_wr.pos = scan_pos_r;
            slot_wr.val = level_r;
            level_nxt   = level_r + LVL_W'(1);
            state_nxt   = ST_LEVEL;
          end
        end else begin
          // No free slot anywhere: back out as if the tries ran out.
          tries_nxt[didx] = '0;
          slot_wr.en      = 1'b1;
          slot_wr.pos     = {1'b0, cur_pos};
          slot_wr.val     = '0;
          pos_nxt[didx]   = cur_pos + LVL_W'(1);
          level_nxt       = lvl_m1;
          state_nxt       = ST_LEVEL;
        end
      end

      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      n_size_r   <= N_SIZE_RESET;
      level_r    <= LVL_W'(1);
      count_r    <= '0;
      finished_r <= 1'b0;
      for (int i = 0; i < MAX_ELEMS; i++) begin
        tries_r[i] <= '0;
        pos_r[i]   <= LVL_W'(i + 1);
      end
    end else begin
      state_r    <= state_nxt;
      n_size_r   <= n_size_nxt;
      level_r    <= level_nxt;
      count_r    <= count_nxt;
      finished_r <= finished_nxt;
      tries_r    <= tries_nxt;
      pos_r      <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_pos_r  <= scan_pos_nxt;
    probes_r    <= probes_nxt;
    placement_r <= placement_nxt;
    seq_r       <= seq_nxt;
    exh_r       <= exh_nxt;
  end

endmodule

FILE: design/pe_slot_file.sv
module pe_slot_file #(
  parameter int MAX_ELEMS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr,
  input  pe_pkg::slot_wr_t           wr,
  input  logic [pe_pkg::POS_W-1:0]   rd_pos,
  output logic [pe_pkg::NIB_W-1:0]   rd_data,
  input  logic [pe_pkg::LVL_W-1:0]   nn,
  input  logic [pe_pkg::POS_W-1:0]   ovr_pos,
  input  logic [pe_pkg::NIB_W-1:0]   ovr_val,
  output logic [pe_pkg::PLACE_W-1:0] placement
);
  import pe_pkg::*;

  localparam int IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;

  logic [NIB_W-1:0] slot_r   [MAX_ELEMS];
  logic [NIB_W-1:0] slot_nxt [MAX_ELEMS];

  logic [POS_W-1:0] rd_m1;
  logic [POS_W-1:0] wr_m1;
  logic             rd_ok;
  logic             wr_ok;

  // Positions are numbered from one; anything outside the store reads as free.
  assign rd_m1 = rd_pos - POS_W'(1);
  assign wr_m1 = wr.pos - POS_W'(1);
  assign rd_ok = (rd_pos != '0) && (rd_pos <= POS_W'(MAX_ELEMS));
  assign wr_ok = (wr.pos != '0) && (wr.pos <= POS_W'(MAX_ELEMS));

  assign rd_data = rd_ok ? slot_r[rd_m1[IDX_W-1:0]] : '0;

  always_comb begin
    slot_nxt = slot_r;
    if (clr) begin
      for (int i = 0; i < MAX_ELEMS; i++) begin
        slot_nxt[i] = '0;
      end
    end else if (wr.en && wr_ok) begin
      slot_nxt[wr_m1[IDX_W-1:0]] = wr.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ELEMS; i++) begin
        slot_r[i] <= '0;
      end
    end else begin
      slot_r <= slot_nxt;
    end
  end

  // Packed view of positions 1..nn, with the value being placed folded in.
  always_comb begin
    placement = '0;
    for (int p = 0; p < MAX_ELEMS; p++) begin
      if (LVL_W'(p) < nn) begin
        if (POS_W'(p + 1) == ovr_pos) begin
          placement[NIB_W*p +: NIB_W] = ovr_val;
        end else begin
          placement[NIB_W*p +: NIB_W] = slot_r[p];
        end
      end
    end
  end

endmodule

FILE: design/pe_check.sv
module pe_check (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [pe_pkg::LVL_W-1:0]   cfg_n_size,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_restart,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [pe_pkg::PLACE_W-1:0] out_placement,
  input logic [pe_pkg::SEQ_W-1:0]   out_sequence_number,
  input logic                       out_exhausted
);

  // A request holds the input side until its word has been delivered.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again before the result word was delivered");

  a_busy_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input side open while a result word is pending");

  a_exhausted_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exhausted |-> out_placement == '0)
    else $error("exhausted word carries a placement");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_exhausted |-> out_sequence_number != '0)
    else $error("permutation word with a zero sequence number");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_placement)
      && $stable(out_sequence_number) && $stable(out_exhausted))
    else $error("stalled result word changed");

endmodule

bind permutation_enumerator pe_check u_pe_check (.*);
